### hdl/lbp_pkg.sv
// lbp_pkg: shared types and constants of the local binary pattern unit
`timescale 1ns / 1ps
`default_nettype none
package lbp_pkg;

  // configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;

  // register widths and reset values
  localparam int FW_BITS = 11;
  localparam int FH_BITS = 16;
  localparam logic [FW_BITS-1:0] FW_RESET = 11'd640;
  localparam logic [FH_BITS-1:0] FH_RESET = 16'd480;

  // smallest frame side in use
  localparam int MIN_DIM = 3;

  // payload widths
  localparam int PIX_IN_BITS  = 8;
  localparam int CODE_BITS    = 9;
  localparam int ROW_BITS     = 16;
  localparam int COL_OUT_BITS = 10;

  // per-pixel flags handed from the scan counters to the pipeline
  typedef struct packed {
    logic emit;
    logic last;
  } scan_t;

endpackage
`default_nettype wire

### hdl/local_binary_pattern_3x3_unit.sv
// local_binary_pattern_3x3_unit: top level of the 3x3 local binary pattern unit
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------------------
//  pixel in | pixel_valid_i/pixel_stall_o | pixel_i, frame_start_i
//  code out | code_valid_o/code_stall_i   | code_o, centre_row_o, centre_col_o, last_o
//  config   | cfg_valid_i/cfg_ready_o     | cfg_index_i, cfg_data_i
//
// One pixel per cycle unless a code stalls; a code trails its centre's below-right pixel.
// Both line buffers share one dual-port ram, read at accept, written when stage 1 moves on.
// A same-address write then read (restart right after column 0) is forwarded.
// Reset clears counters, window and valids; the ram needs no clearing pass.
// A stall on the output holds the pipeline only when a code waits for the output register.
`timescale 1ns / 1ps
`default_nettype none
module local_binary_pattern_3x3_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // pixel channel
  input  wire logic                              pixel_valid_i,
  output logic                                   pixel_stall_o,
  input  wire logic [lbp_pkg::PIX_IN_BITS-1:0]   pixel_i,
  input  wire logic                              frame_start_i,
  // code channel
  output logic                                   code_valid_o,
  input  wire logic                              code_stall_i,
  output logic      [lbp_pkg::CODE_BITS-1:0]     code_o,
  output logic      [lbp_pkg::ROW_BITS-1:0]      centre_row_o,
  output logic      [lbp_pkg::COL_OUT_BITS-1:0]  centre_col_o,
  output logic                                   last_o,
  // configuration channel
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [lbp_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  wire logic [lbp_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);
  import lbp_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int PB = PIXEL_BITS;

  // configuration registers
  logic [FW_BITS-1:0] frame_width_q;
  logic [FH_BITS-1:0] frame_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FW_RESET;
      frame_height_q <= FH_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[FW_BITS-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[FH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // handshake and pipeline control
  logic pix_acc;
  logic s1_valid_q;
  logic s1_go;
  logic out_free;
  logic out_valid_q;

  scan_t               s0_flags;
  logic [AW-1:0]       s0_col;
  logic [ROW_BITS-1:0] s0_row;
  logic [15:0]         pix_ext;
  logic [PB-1:0]       s0_px;

  scan_t               s1_flags_q;
  logic [AW-1:0]       s1_col_q;
  logic [ROW_BITS-1:0] s1_row_q;
  logic [PB-1:0]       s1_px_q;
  logic                fwd_q;
  logic [2*PB-1:0]     fwd_data_q;

  logic [2*PB-1:0]     ram_rdata;
  logic [2*PB-1:0]     line_rd;
  logic [2*PB-1:0]     line_wr;
  logic [PB-1:0]       top_px, mid_px;
  logic [CODE_BITS-1:0] s1_code;

  assign out_free      = !out_valid_q || !code_stall_i;
  assign s1_go         = s1_valid_q && (!s1_flags_q.emit || out_free);
  assign pixel_stall_o = s1_valid_q && !s1_go;
  assign pix_acc       = pixel_valid_i && !pixel_stall_o;

  // low pixel bits in use
  assign pix_ext = {8'b0, pixel_i};
  assign s0_px   = pix_ext[PB-1:0];

  lbp_scan #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (pix_acc),
    .frame_start_i  (frame_start_i),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .col_o          (s0_col),
    .row_o          (s0_row),
    .flags_o        (s0_flags)
  );

  // line buffer entry: {row r-2, row r-1}
  lbp_ram #(
    .WIDTH(2 * PB),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_go),
    .waddr_i (s1_col_q),
    .wdata_i (line_wr),
    .re_i    (pix_acc),
    .raddr_i (s0_col),
    .rdata_o (ram_rdata)
  );

  // stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_flags_q <= '0;
      fwd_q      <= 1'b0;
    end else if (pix_acc) begin
      s1_valid_q <= 1'b1;
      s1_flags_q <= s0_flags;
      fwd_q      <= s1_valid_q && (s1_col_q == s0_col);
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      s1_col_q   <= s0_col;
      s1_row_q   <= s0_row;
      s1_px_q    <= s0_px;
      fwd_data_q <= line_wr;
    end
  end

  // forward a write that collided with the read
  assign line_rd = fwd_q ? fwd_data_q : ram_rdata;
  assign top_px  = line_rd[2*PB-1:PB];
  assign mid_px  = line_rd[PB-1:0];
  assign line_wr = {mid_px, s1_px_q};

  lbp_code #(
    .PIXEL_BITS(PB)
  ) u_code (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_go),
    .top_i  (top_px),
    .mid_i  (mid_px),
    .bot_i  (s1_px_q),
    .code_o (s1_code)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_flags_q.emit) begin
      out_valid_q <= 1'b1;
    end else if (!code_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_flags_q.emit) begin
      code_o       <= s1_code;
      centre_row_o <= s1_row_q - 1'b1;
      centre_col_o <= COL_OUT_BITS'(s1_col_q - 1'b1);
      last_o       <= s1_flags_q.last;
    end
  end

  assign code_valid_o = out_valid_q;

  // an accepted pixel always reaches stage 1
  assert property (@(posedge clk_i) disable iff (!rst_ni) pix_acc |=> s1_valid_q)
    else $error("accepted pixel did not enter stage 1");

  // input is held back only by a pending code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixel_stall_o |-> (s1_valid_q && s1_flags_q.emit && out_valid_q && code_stall_i))
    else $error("input stalled without a blocked code");

  // codes are interior and keep bit 0 clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    code_valid_o |-> (code_o[0] == 1'b0) && (centre_row_o != '0))
    else $error("code out of range");

  // forwarding only follows an accept with stage 1 busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_acc && !s1_valid_q) |=> !fwd_q)
    else $error("forwarding without a preceding write");

endmodule
`default_nettype wire

### hdl/lbp_ram.sv
// lbp_ram: generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module lbp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, old data on a same-address collision
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### hdl/lbp_scan.sv
// lbp_scan: raster position counters and frame geometry
`timescale 1ns / 1ps
`default_nettype none
module lbp_scan #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            advance_i,
  input  wire logic                            frame_start_i,
  input  wire logic [lbp_pkg::FW_BITS-1:0]     frame_width_i,
  input  wire logic [lbp_pkg::FH_BITS-1:0]     frame_height_i,
  output logic      [$clog2(MAX_WIDTH)-1:0]    col_o,
  output logic      [lbp_pkg::ROW_BITS-1:0]    row_o,
  output lbp_pkg::scan_t                       flags_o
);
  import lbp_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = AW + 1;

  logic [AW-1:0]       col_q, col_d;
  logic [ROW_BITS-1:0] row_q, row_d;
  logic [WW-1:0]       w_use;
  logic [FH_BITS-1:0]  h_use;
  logic [AW-1:0]       col_cur;
  logic [ROW_BITS-1:0] row_pre, row_cur;
  logic [WW-1:0]       col_inc;
  logic [ROW_BITS:0]   row_inc;

  // geometry in use: width clamped, height at least the minimum
  always_comb begin
    if (int'(frame_width_i) < MIN_DIM) begin
      w_use = WW'(MIN_DIM);
    end else if (int'(frame_width_i) > MAX_WIDTH) begin
      w_use = WW'(MAX_WIDTH);
    end else begin
      w_use = WW'(frame_width_i);
    end
    if (int'(frame_height_i) < MIN_DIM) begin
      h_use = FH_BITS'(MIN_DIM);
    end else begin
      h_use = frame_height_i;
    end
  end

  // position of the pixel now offered, after restart and wrap
  always_comb begin
    priority if (frame_start_i) begin
      col_cur = '0;
      row_pre = '0;
    end else if ({1'b0, col_q} >= w_use) begin
      col_cur = '0;
      row_pre = row_q + 1'b1;
    end else begin
      col_cur = col_q;
      row_pre = row_q;
    end
    row_cur = (row_pre >= h_use) ? '0 : row_pre;
  end

  // position after this pixel
  always_comb begin
    col_inc = {1'b0, col_cur} + 1'b1;
    row_inc = {1'b0, row_cur} + 1'b1;
    if (col_inc >= w_use) begin
      col_d = '0;
      row_d = (row_inc >= {1'b0, h_use}) ? '0 : row_inc[ROW_BITS-1:0];
    end else begin
      col_d = col_inc[AW-1:0];
      row_d = row_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (advance_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // interior centre sits one up and one left of the pixel
  assign col_o         = col_cur;
  assign row_o         = row_cur;
  assign flags_o.emit  = (row_cur >= ROW_BITS'(2)) && (int'(col_cur) >= 2);
  assign flags_o.last  = (row_cur == h_use - 1'b1) && ({1'b0, col_cur} == w_use - 1'b1);

endmodule
`default_nettype wire

### hdl/lbp_code.sv
// lbp_code: 3x3 window columns and neighbour comparison
`timescale 1ns / 1ps
`default_nettype none
module lbp_code #(
  parameter int PIXEL_BITS = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire logic [PIXEL_BITS-1:0]         top_i,
  input  wire logic [PIXEL_BITS-1:0]         mid_i,
  input  wire logic [PIXEL_BITS-1:0]         bot_i,
  output logic      [lbp_pkg::CODE_BITS-1:0] code_o
);
  import lbp_pkg::*;

  // [0..2] column c-2 top/mid/bottom, [3..5] column c-1
  logic [PIXEL_BITS-1:0] win_q [6];
  logic [PIXEL_BITS-1:0] centre;
  logic [7:0]            ge;

  // shift in the new column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (step_i) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top_i;
      win_q[4] <= mid_i;
      win_q[5] <= bot_i;
    end
  end

  // centre >= neighbour, raster-order weights from top-left
  always_comb begin
    centre = win_q[4];
    ge[0]  = centre >= win_q[0];
    ge[1]  = centre >= win_q[3];
    ge[2]  = centre >= top_i;
    ge[3]  = centre >= win_q[1];
    ge[4]  = centre >= mid_i;
    ge[5]  = centre >= win_q[2];
    ge[6]  = centre >= win_q[5];
    ge[7]  = centre >= bot_i;
  end

  // weight of neighbour k is 2^(k+1), bit 0 stays clear
  assign code_o = {ge, 1'b0};

endmodule
`default_nettype wire

### verif/tb_local_binary_pattern_3x3_unit.sv
// tb_local_binary_pattern_3x3_unit: self-checking testbench of the 3x3 local binary pattern unit
`timescale 1ns / 1ps
module tb_local_binary_pattern_3x3_unit;
  import lbp_pkg::*;

  localparam int MAX_W        = 1024;
  localparam int PIX_BITS     = 8;
  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_ITEMS = 780;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int MAX_REPORTS  = 10;

  // register indexes with no register behind them
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNMAPPED_LO = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNMAPPED_HI = 2'd3;

  typedef struct {
    logic [PIX_IN_BITS-1:0] pixel;
    logic                   frame_start;
  } pixel_item_t;

  typedef struct {
    logic [CODE_BITS-1:0]    code;
    logic [ROW_BITS-1:0]     row;
    logic [COL_OUT_BITS-1:0] col;
    logic                    last;
  } lbp_code_t;

  typedef enum int {PIX_UNIFORM, PIX_NARROW, PIX_EXTREME} pix_style_e;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     pixel_valid_i = 1'b0;
  logic                     pixel_stall_o;
  logic [PIX_IN_BITS-1:0]   pixel_i       = '0;
  logic                     frame_start_i = 1'b0;
  logic                     code_valid_o;
  logic                     code_stall_i  = 1'b0;
  logic [CODE_BITS-1:0]     code_o;
  logic [ROW_BITS-1:0]      centre_row_o;
  logic [COL_OUT_BITS-1:0]  centre_col_o;
  logic                     last_o;
  logic                     cfg_valid_i   = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i   = CFG_FRAME_WIDTH;
  logic [CFG_DATA_BITS-1:0] cfg_data_i    = '0;

  pixel_item_t pixels_pending[$];
  lbp_code_t   lbp_codes_due[$];
  pixel_item_t drv_item;
  lbp_code_t   code_want;

  int unsigned cycle_count   = 0;
  int unsigned fail_count    = 0;
  int unsigned codes_checked = 0;
  int unsigned pixels_sent   = 0;
  int unsigned cfg_writes    = 0;
  int unsigned phase_count   = 0;
  int unsigned src_idle      = 0;
  int unsigned snk_stall     = 0;
  bit          src_gaps_on   = 1'b1;
  bit          snk_stalls_on = 1'b1;

  // mirror of the scan state, with a flag per entry telling if its value is known
  logic [FW_BITS-1:0]  width_reg  = FW_RESET;
  logic [FH_BITS-1:0]  height_reg = FH_RESET;
  logic [PIX_BITS-1:0] older_px [MAX_W];
  logic [PIX_BITS-1:0] newer_px [MAX_W];
  logic [PIX_BITS-1:0] win_px   [6];
  bit                  older_ok [MAX_W];
  bit                  newer_ok [MAX_W];
  bit                  win_ok   [6];
  int unsigned         row_ctr = 0;
  int unsigned         col_ctr = 0;

  local_binary_pattern_3x3_unit #(
    .MAX_WIDTH  (MAX_W),
    .PIXEL_BITS (PIX_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pixel_valid_i (pixel_valid_i),
    .pixel_stall_o (pixel_stall_o),
    .pixel_i       (pixel_i),
    .frame_start_i (frame_start_i),
    .code_valid_o  (code_valid_o),
    .code_stall_i  (code_stall_i),
    .code_o        (code_o),
    .centre_row_o  (centre_row_o),
    .centre_col_o  (centre_col_o),
    .last_o        (last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  always #HALF_PERIOD clk_i = ~clk_i;

  function automatic int unsigned eff_width();
    if (width_reg < MIN_DIM) return MIN_DIM;
    if (width_reg > MAX_W) return MAX_W;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg < MIN_DIM) return MIN_DIM;
    return height_reg;
  endfunction

  // mostly short gaps, a few long ones, none when idling is off
  function automatic int unsigned pick_gap(bit enabled);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // true when every line entry and window value the scan can reach is known
  function automatic bit geometry_safe(int unsigned w);
    foreach (win_ok[k]) if (!win_ok[k]) return 1'b0;
    for (int unsigned c = 0; c < w; c++) begin
      if (!older_ok[c] || !newer_ok[c]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [PIX_IN_BITS-1:0] gen_pixel(pix_style_e style,
                                                      logic [PIX_IN_BITS-1:0] base);
    case (style)
      PIX_NARROW:  return base + PIX_IN_BITS'($urandom_range(0, 2));
      PIX_EXTREME: return ($urandom_range(0, 1) != 0) ? '1 : '0;
      default:     return PIX_IN_BITS'($urandom);
    endcase
  endfunction

  // advance the scan by one pixel and queue the code it completes, if any
  task automatic step_lbp_scan(input logic [PIX_IN_BITS-1:0] px, input logic restart);
    int unsigned         w;
    int unsigned         h;
    logic [PIX_BITS-1:0] top;
    logic [PIX_BITS-1:0] mid;
    logic [PIX_BITS-1:0] ctr;
    bit                  top_ok;
    bit                  mid_ok;
    lbp_code_t           res;
    w = eff_width();
    h = eff_height();
    if (restart) begin
      row_ctr = 0;
      col_ctr = 0;
    end else if (col_ctr >= w) begin
      col_ctr = 0;
      row_ctr++;
    end
    if (row_ctr >= h) row_ctr = 0;
    top    = older_px[col_ctr];
    mid    = newer_px[col_ctr];
    top_ok = older_ok[col_ctr];
    mid_ok = newer_ok[col_ctr];
    // neighbour bits from top-left (bit 1) to bottom-right (bit 8)
    if (row_ctr >= 2 && col_ctr >= 2) begin
      ctr      = win_px[4];
      res.code = {ctr >= px, ctr >= win_px[5], ctr >= win_px[2], ctr >= mid,
                  ctr >= win_px[1], ctr >= top, ctr >= win_px[3], ctr >= win_px[0], 1'b0};
      res.row  = ROW_BITS'(row_ctr - 1);
      res.col  = COL_OUT_BITS'(col_ctr - 1);
      res.last = (row_ctr - 1 == h - 2) && (col_ctr - 1 == w - 2);
      lbp_codes_due.push_back(res);
    end
    // shift the window by one column
    for (int k = 0; k < 3; k++) begin
      win_px[k] = win_px[k + 3];
      win_ok[k] = win_ok[k + 3];
    end
    win_px[3] = top;
    win_px[4] = mid;
    win_px[5] = px;
    win_ok[3] = top_ok;
    win_ok[4] = mid_ok;
    win_ok[5] = 1'b1;
    older_px[col_ctr] = mid;
    older_ok[col_ctr] = mid_ok;
    newer_px[col_ctr] = px;
    newer_ok[col_ctr] = 1'b1;
    col_ctr++;
    if (col_ctr >= w) begin
      col_ctr = 0;
      row_ctr++;
      if (row_ctr >= h) row_ctr = 0;
    end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_FRAME_WIDTH:  width_reg = data[FW_BITS-1:0];
      CFG_FRAME_HEIGHT: height_reg = data[FH_BITS-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic queue_pixels(int unsigned n, bit start_frame, pix_style_e style, bit noisy);
    pixel_item_t            item;
    logic [PIX_IN_BITS-1:0] base;
    base = PIX_IN_BITS'($urandom);
    for (int unsigned k = 0; k < n; k++) begin
      item.pixel       = gen_pixel(style, base);
      item.frame_start = (k == 0) ? start_frame : (noisy && $urandom_range(0, 199) == 0);
      pixels_pending.push_back(item);
    end
  endtask

  // wait until every pixel is taken and every code is back, then let the pipe settle
  task automatic wait_idle();
    while (pixels_pending.size() != 0 || pixel_valid_i || lbp_codes_due.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    phase_count++;
  endtask

  // pixel driver: runs the predictor on each transfer, then presents the next pixel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pixel_valid_i && !pixel_stall_o) begin
        step_lbp_scan(pixel_i, frame_start_i);
        pixels_sent++;
      end
      if (!pixel_valid_i || !pixel_stall_o) begin
        if (src_idle > 0) begin
          pixel_valid_i <= 1'b0;
          src_idle--;
        end else if (pixels_pending.size() != 0) begin
          drv_item = pixels_pending.pop_front();
          pixel_valid_i <= 1'b1;
          pixel_i       <= drv_item.pixel;
          frame_start_i <= drv_item.frame_start;
          src_idle = pick_gap(src_gaps_on);
        end else begin
          pixel_valid_i <= 1'b0;
        end
      end
    end
  end

  // code monitor: checks each transfer against the oldest expected code, drives stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (code_valid_o && !code_stall_i) begin
        if (lbp_codes_due.size() == 0) begin
          if (fail_count < MAX_REPORTS)
            $display("unexpected code transfer: code=%0d row=%0d col=%0d last=%0b",
                     code_o, centre_row_o, centre_col_o, last_o);
          fail_count++;
        end else begin
          code_want = lbp_codes_due.pop_front();
          codes_checked++;
          if (code_o !== code_want.code || centre_row_o !== code_want.row ||
              centre_col_o !== code_want.col || last_o !== code_want.last) begin
            if (fail_count < MAX_REPORTS)
              $display("code mismatch: expected code=%0d row=%0d col=%0d last=%0b,",
                       code_want.code, code_want.row, code_want.col, code_want.last,
                       " got code=%0d row=%0d col=%0d last=%0b",
                       code_o, centre_row_o, centre_col_o, last_o);
            fail_count++;
          end
        end
      end
      if (snk_stall > 0) begin
        code_stall_i <= 1'b1;
        snk_stall--;
      end else begin
        code_stall_i <= 1'b0;
        snk_stall = pick_gap(snk_stalls_on);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d codes still expected",
               cycle_count, lbp_codes_due.size());
      $display("local_binary_pattern_3x3_unit verification failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [PIX_IN_BITS-1:0]   directed_px [30];
    pixel_item_t              item;
    logic [CFG_DATA_BITS-1:0] cfg_word;
    int unsigned              wv;
    int unsigned              hv;
    int unsigned              fr;
    int unsigned              n;
    int unsigned              random_items;
    bit                       need_restart;
    pix_style_e               style;

    foreach (win_px[k]) begin
      win_px[k] = '0;
      win_ok[k] = 1'b1;
    end
    foreach (older_px[c]) begin
      older_px[c] = '0;
      newer_px[c] = '0;
    end
    random_items = 0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: 3x3 frames - dark centre in a bright ring, mixed ties, restart mid-frame
    cfg_write(CFG_FRAME_WIDTH, 16'd3);
    cfg_write(CFG_FRAME_HEIGHT, 16'd3);
    directed_px = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255,
                    8'd127, 8'd128, 8'd129, 8'd0,   8'd128, 8'd255, 8'd128, 8'd129, 8'd127,
                    8'd0,   8'd255, 8'd17,
                    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
    for (int k = 0; k < 30; k++) begin
      item.pixel       = directed_px[k];
      item.frame_start = (k == 0 || k == 21);
      pixels_pending.push_back(item);
    end
    wait_idle();

    // widest row through the upper clamp, height below the minimum: one full row
    // and the first two pixels of the next
    cfg_write(CFG_FRAME_WIDTH, 16'hFFFF);
    cfg_write(CFG_FRAME_HEIGHT, 16'h0000);
    queue_pixels(MAX_W + 2, 1'b1, PIX_UNIFORM, 1'b0);
    wait_idle();

    // narrowest width through the lower clamp, same frame carried on, tallest frame
    // left unfinished; the row count shows where the wide row wrapped
    cfg_write(CFG_FRAME_WIDTH, 16'hF801);
    cfg_write(CFG_FRAME_HEIGHT, 16'hFFFF);
    queue_pixels(45, 1'b0, PIX_NARROW, 1'b0);
    wait_idle();

    // height cut below the current row: row wraps with no frame start
    cfg_write(CFG_UNMAPPED_LO, CFG_DATA_BITS'($urandom));
    cfg_write(CFG_UNMAPPED_HI, CFG_DATA_BITS'($urandom));
    cfg_write(CFG_FRAME_HEIGHT, 16'd2);
    queue_pixels(20, 1'b0, PIX_EXTREME, 1'b0);
    wait_idle();

    // random geometry, content and idling per phase
    while (random_items < RANDOM_ITEMS) begin
      src_gaps_on   = ($urandom_range(0, 3) != 0);
      snk_stalls_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(0, 99);
      if (n < 70) wv = $urandom_range(3, 12);
      else if (n < 85) wv = $urandom_range(13, 40);
      else if (n < 92) wv = $urandom_range(0, 2);
      else wv = $urandom_range(41, 100);
      n = $urandom_range(0, 99);
      if (wv > 12) hv = $urandom_range(3, 6);
      else if (n < 70) hv = $urandom_range(3, 8);
      else if (n < 85) hv = $urandom_range(9, 20);
      else hv = $urandom_range(0, 2);
      if ($urandom_range(0, 9) < 6) begin
        cfg_word = CFG_DATA_BITS'($urandom);
        cfg_word[FW_BITS-1:0] = FW_BITS'(wv);
        cfg_write(CFG_FRAME_WIDTH, cfg_word);
      end
      if ($urandom_range(0, 9) < 6) cfg_write(CFG_FRAME_HEIGHT, CFG_DATA_BITS'(hv));
      if ($urandom_range(0, 19) == 0) cfg_write(CFG_UNMAPPED_HI, CFG_DATA_BITS'($urandom));
      // a mid-frame change is only kept when no unknown line value can reach a code
      need_restart = (row_ctr != 0 || col_ctr != 0) && !geometry_safe(eff_width());
      fr = eff_width() * eff_height();
      n = 600 / fr;
      if (n < 1) n = 1;
      if (n > 3) n = 3;
      n = n * fr;
      if ($urandom_range(0, 9) < 4) n += $urandom_range(1, fr - 1);
      style = pix_style_e'($urandom_range(0, 2));
      queue_pixels(n, need_restart || $urandom_range(0, 9) < 7, style, 1'b1);
      random_items += n;
      wait_idle();
    end

    $display("covered %0d pixel transfers in %0d phases with %0d codes checked",
             pixels_sent, phase_count, codes_checked);
    $display("widths 3 to %0d incl. clamps, heights 3 to 65535, %0d register writes",
             MAX_W, cfg_writes);
    if (fail_count == 0 && lbp_codes_due.size() == 0) begin
      $display("local_binary_pattern_3x3_unit verification clean");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("local_binary_pattern_3x3_unit verification failed");
    end
    $finish;
  end

endmodule
